// File: sv/dq_pkg.sv
// Shared constants, request and status codes for the circular deque.
package dq_pkg;

	localparam int DEPTH = 128;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int OCC_W = 8;

	typedef enum logic [2:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_PEEK_FRONT = 3'd4,
		REQ_PEEK_BACK  = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

endpackage

// File: sv/dq_req_if.sv
// Request channel of the circular deque: valid/ready handshake and request payload.
interface dq_req_if
	import dq_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [2:0]        req_type;
	logic signed [31:0] write_value;

	modport source (output valid, output req_type, output write_value, input ready);
	modport sink (input valid, input req_type, input write_value, output ready);
endinterface

// File: sv/dq_rsp_if.sv
// Response channel of the circular deque: valid/ready handshake and result payload.
interface dq_rsp_if
	import dq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic [OCC_W-1:0]   occupancy;
	logic               is_empty;

	modport source (output valid, output read_value, output status, output occupancy,
		output is_empty, input ready);
	modport sink (input valid, input read_value, input status, input occupancy,
		input is_empty, output ready);
endinterface

// File: sv/circular_deque.sv
// Circular deque top level: ring store in a RAM with head, tail and count registers.
//
// Requests arrive on the req channel (push front/back, pop front/back, peek
// front/back) and each one yields exactly one item on the rsp channel, in order.
// Every response carries the word read, a status code, the occupancy after the
// request and an empty flag.
// Pushes, refused pushes, requests on an empty deque and unknown codes answer in
// the cycle after acceptance, and a new request can be taken every cycle while the
// output register is free. A pop or peek of a held entry needs a read of the
// storage RAM, whose read data is registered; it answers once that data returns
// and blocks the req channel while the read is pending.
// Results wait in a single output register; a new request is taken only when
// that register is empty or being drained in the same cycle, so a stalled
// receiver stalls the sender after one item.
// Reset clears head, tail, count and all valid flags; the storage RAM is not
// cleared, since only entries that were written are ever read.
module circular_deque
	import dq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);
	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	logic                  rd_pend_s1;
	logic [CNT_W-1:0]      occ_s1;

	logic                  rsp_valid_q;
	logic signed [31:0]    rd_val_q;
	logic [1:0]            status_q;
	logic [OCC_W-1:0]      occ_q;
	logic                  empty_q;

	logic                  accept;
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_addr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// Direct (no RAM read) result computed at acceptance.
	logic                  direct_vld;
	logic signed [31:0]    direct_val;
	status_t               direct_st;
	logic [CNT_W-1:0]      direct_occ;
	logic                  read_vld;
	logic [CNT_W-1:0]      read_occ;

	logic full, empty;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		idx_inc = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
		idx_dec = (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
	endfunction

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);

	assign req.ready = !rd_pend_s1 && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		cnt_d      = cnt_q;
		ram_we     = 1'b0;
		ram_addr   = head_q;
		direct_vld = 1'b0;
		direct_val = '0;
		direct_st  = ST_OK;
		direct_occ = cnt_q;
		read_vld   = 1'b0;
		read_occ   = cnt_q;
		if (accept) begin
			unique case (req.req_type) inside
				REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
					direct_vld = 1'b1;
					if (full) begin
						direct_st = ST_OVERFLOW;
					end else begin
						ram_we = 1'b1;
						cnt_d  = cnt_q + 1'b1;
						direct_occ = cnt_q + 1'b1;
						if (empty) begin
							head_d   = '0;
							tail_d   = '0;
							ram_addr = '0;
						end else if (req.req_type == REQ_PUSH_FRONT) begin
							head_d   = idx_dec(head_q);
							ram_addr = idx_dec(head_q);
						end else begin
							tail_d   = idx_inc(tail_q);
							ram_addr = idx_inc(tail_q);
						end
					end
				end
				REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
					if (empty) begin
						direct_vld = 1'b1;
						direct_val = '1;
						direct_st  = ST_UNDERFLOW;
					end else begin
						read_vld = 1'b1;
						ram_addr = (req.req_type == REQ_POP_FRONT ||
							req.req_type == REQ_PEEK_FRONT) ? head_q : tail_q;
						if (req.req_type == REQ_POP_FRONT || req.req_type == REQ_POP_BACK) begin
							cnt_d    = cnt_q - 1'b1;
							read_occ = cnt_q - 1'b1;
							if (cnt_q == CNT_W'(1)) begin
								head_d = '0;
								tail_d = '0;
							end else if (req.req_type == REQ_POP_FRONT) begin
								head_d = idx_inc(head_q);
							end else begin
								tail_d = idx_dec(tail_q);
							end
						end
					end
				end
				default: begin
					// Undefined request codes leave the state alone.
					direct_vld = 1'b1;
				end
			endcase
		end
	end

	dq_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(req.write_value[DATA_WIDTH-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			rd_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			head_q     <= head_d;
			tail_q     <= tail_d;
			cnt_q      <= cnt_d;
			rd_pend_s1 <= read_vld;
			if (direct_vld || rd_pend_s1) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (read_vld) begin
			occ_s1 <= read_occ;
		end
		if (direct_vld) begin
			rd_val_q <= direct_val;
			status_q <= direct_st;
			occ_q    <= OCC_W'(direct_occ);
			empty_q  <= (direct_occ == '0);
		end else if (rd_pend_s1) begin
			rd_val_q <= 32'(signed'(ram_rdata));
			status_q <= ST_OK;
			occ_q    <= OCC_W'(occ_s1);
			empty_q  <= (occ_s1 == '0);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rd_val_q;
	assign rsp.status     = status_q;
	assign rsp.occupancy  = occ_q;
	assign rsp.is_empty   = empty_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> head_q == '0 && tail_q == '0)
		else $error("indices not at zero while empty");

	a_pend_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !rsp_valid_q)
		else $error("read completes into an occupied output register");

	a_pend_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> !req.ready)
		else $error("request taken during a pending read");

	a_read_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |=> rsp_valid_q)
		else $error("pending read did not produce a result");
endmodule

// File: sv/dq_ram.sv
// Generic single-port synchronous RAM with registered read data.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// File: test/circular_deque_tb.sv
// Self-checking testbench for the circular deque: directed table, random traffic, predictor.
module circular_deque_tb
	import dq_pkg::*;
;

	localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [2:0] REQ_UNUSED_7 = 3'd7;
	localparam logic signed [31:0] MIN_WORD = 32'sh8000_0000;
	localparam logic signed [31:0] MAX_WORD = 32'sh7fff_ffff;
	localparam logic signed [31:0] EMPTY_WORD = -32'sd1;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int REPLY_SLOTS = 64;

	typedef struct packed {
		logic signed [31:0] read_value;
		status_t            status;
		logic [OCC_W-1:0]   occupancy;
		logic               is_empty;
	} dq_reply_t;

	typedef struct packed {
		logic [2:0]         code;
		logic signed [31:0] word;
		logic               fixed;
		dq_reply_t          reply;
	} dq_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	circular_deque dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the deque contents and pointers.
	logic signed [31:0] ring [DEPTH];
	int front_idx = 0;
	int back_idx = 0;
	int held = 0;

	// Replies still owed by the block, oldest first.
	dq_reply_t reply_slots [REPLY_SLOTS];
	logic [5:0] reply_wr_ptr = '0;
	logic [5:0] reply_rd_ptr = '0;
	int reply_cnt = 0;

	int failures = 0;
	bit no_idle = 1'b0;
	bit long_hold_req = 1'b0;

	// Rows with fixed = 1 carry the reply written out in the table; the others
	// are checked against the predictor.
	dq_row_t directed_rows [0:21] = '{
		'{REQ_PEEK_FRONT, 32'sd0, 1'b1, '{EMPTY_WORD, ST_UNDERFLOW, 8'd0, 1'b1}},
		'{REQ_PEEK_BACK, 32'sd0, 1'b1, '{EMPTY_WORD, ST_UNDERFLOW, 8'd0, 1'b1}},
		'{REQ_POP_FRONT, 32'sd0, 1'b1, '{EMPTY_WORD, ST_UNDERFLOW, 8'd0, 1'b1}},
		'{REQ_POP_BACK, 32'sd0, 1'b1, '{EMPTY_WORD, ST_UNDERFLOW, 8'd0, 1'b1}},
		'{REQ_UNUSED_6, MAX_WORD, 1'b1, '{32'sd0, ST_OK, 8'd0, 1'b1}},
		'{REQ_UNUSED_7, EMPTY_WORD, 1'b1, '{32'sd0, ST_OK, 8'd0, 1'b1}},
		'{REQ_PUSH_BACK, MAX_WORD, 1'b1, '{32'sd0, ST_OK, 8'd1, 1'b0}},
		'{REQ_PUSH_FRONT, MIN_WORD, 1'b1, '{32'sd0, ST_OK, 8'd2, 1'b0}},
		'{REQ_PEEK_FRONT, 32'sd0, 1'b1, '{MIN_WORD, ST_OK, 8'd2, 1'b0}},
		'{REQ_PEEK_BACK, 32'sd0, 1'b1, '{MAX_WORD, ST_OK, 8'd2, 1'b0}},
		'{REQ_PUSH_BACK, 32'sd0, 1'b0, '0},
		'{REQ_PUSH_FRONT, EMPTY_WORD, 1'b0, '0},
		'{REQ_UNUSED_7, 32'sh5555_5555, 1'b0, '0},
		'{REQ_POP_BACK, 32'sd0, 1'b0, '0},
		'{REQ_POP_FRONT, 32'sd0, 1'b0, '0},
		'{REQ_POP_FRONT, 32'sd0, 1'b1, '{MIN_WORD, ST_OK, 8'd1, 1'b0}},
		'{REQ_POP_BACK, 32'sd0, 1'b1, '{MAX_WORD, ST_OK, 8'd0, 1'b1}},
		'{REQ_PUSH_FRONT, 32'sh1234_5678, 1'b0, '0},
		'{REQ_POP_BACK, 32'sd0, 1'b0, '0},
		'{REQ_PUSH_BACK, 32'sha5a5_0f0f, 1'b0, '0},
		'{REQ_PEEK_FRONT, 32'sd0, 1'b0, '0},
		'{REQ_POP_FRONT, 32'sd0, 1'b0, '0}
	};

	// Applies one request to the shadow deque and returns the reply it should produce.
	function automatic dq_reply_t predict_reply(input logic [2:0] code,
			input logic signed [31:0] word);
		dq_reply_t r;
		bit from_front;
		r.read_value = 32'sd0;
		r.status = ST_OK;
		from_front = (code == REQ_POP_FRONT || code == REQ_PEEK_FRONT);
		case (code) inside
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (held >= DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					if (held == 0) begin
						front_idx = 0;
						back_idx = 0;
						ring[0] = word;
					end else if (code == REQ_PUSH_FRONT) begin
						front_idx = (front_idx + DEPTH - 1) % DEPTH;
						ring[front_idx] = word;
					end else begin
						back_idx = (back_idx + 1) % DEPTH;
						ring[back_idx] = word;
					end
					held++;
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
				if (held == 0) begin
					r.status = ST_UNDERFLOW;
					r.read_value = EMPTY_WORD;
				end else begin
					r.read_value = ring[from_front ? front_idx : back_idx];
					if (code == REQ_POP_FRONT || code == REQ_POP_BACK) begin
						if (held == 1) begin
							front_idx = 0;
							back_idx = 0;
						end else if (from_front) begin
							front_idx = (front_idx + 1) % DEPTH;
						end else begin
							back_idx = (back_idx + DEPTH - 1) % DEPTH;
						end
						held--;
					end
				end
			end
			default: ;
		endcase
		r.occupancy = held[OCC_W-1:0];
		r.is_empty = (held == 0);
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_request(input logic [2:0] code, input logic signed [31:0] word,
			input int gap, input logic fixed, input dq_reply_t fixed_reply);
		dq_reply_t predicted;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= code;
		req_ch.write_value <= word;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = predict_reply(code, word);
		reply_slots[reply_wr_ptr] = fixed ? fixed_reply : predicted;
		reply_wr_ptr = reply_wr_ptr + 6'd1;
		reply_cnt++;
		@(negedge clk);
	endtask

	task automatic wait_for_replies();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (reply_cnt != 0);
	endtask

	task automatic run_traffic(input int count, input int push_pct, input int pop_pct,
			input bit idle_ok);
		logic [2:0] code;
		logic signed [31:0] word;
		int roll;
		int gap;
		bit tx_quiet;
		tx_quiet = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (n % 25 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 3)
				code = $urandom_range(0, 1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
			else if (roll < 3 + push_pct)
				code = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
			else if (roll < 3 + push_pct + pop_pct)
				code = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
			else
				code = $urandom_range(0, 1) ? REQ_PEEK_BACK : REQ_PEEK_FRONT;
			if ($urandom_range(0, 15) == 0) begin
				case ($urandom_range(0, 3))
					0: word = MIN_WORD;
					1: word = MAX_WORD;
					2: word = 32'sd0;
					default: word = EMPTY_WORD;
				endcase
			end else begin
				word = $urandom();
			end
			gap = (idle_ok && !tx_quiet && $urandom_range(0, 4) == 0) ?
				$urandom_range(1, 19) : 0;
			send_request(code, word, gap, 1'b0, '0);
		end
	endtask

	// Receiver: random stall bursts, an occasional quiet stretch, and one long hold-off.
	initial begin
		bit rx_quiet;
		rx_quiet = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!no_idle && !rx_quiet && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19) - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_replies
		dq_reply_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (reply_cnt == 0) begin
				$error("unexpected reply: read_value %0d status %0d occupancy %0d",
					rsp_ch.read_value, rsp_ch.status, rsp_ch.occupancy);
				failures++;
			end else begin
				want = reply_slots[reply_rd_ptr];
				reply_rd_ptr = reply_rd_ptr + 6'd1;
				reply_cnt--;
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value,
						rsp_ch.read_value);
					failures++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", int'(want.status), rsp_ch.status);
					failures++;
				end
				if (rsp_ch.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						rsp_ch.occupancy);
					failures++;
				end
				if (rsp_ch.is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty,
						rsp_ch.is_empty);
					failures++;
				end
			end
		end
	end

	// Ends the run if neither channel moves an item for too long.
	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
					(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				stalled = 0;
			else
				stalled++;
		end
		$display("circular_deque: mismatch");
		$finish;
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_PUSH_FRONT;
		req_ch.write_value = 32'sd0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].code, directed_rows[i].word,
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0,
				directed_rows[i].fixed, directed_rows[i].reply);
		wait_for_replies();

		run_traffic(120, 40, 35, 1'b1);
		wait_for_replies();

		// Mostly pushes: the deque fills and refuses further pushes. The receiver
		// holds off at the start so the request side backs up.
		long_hold_req = 1'b1;
		run_traffic(200, 90, 5, 1'b1);
		wait_for_replies();

		// Mostly pops: the deque drains and then underflows.
		run_traffic(180, 7, 88, 1'b1);
		wait_for_replies();

		no_idle = 1'b1;
		run_traffic(50, 40, 35, 1'b0);
		wait_for_replies();
		repeat (4) @(negedge clk);

		if (failures == 0)
			$display("circular_deque: match");
		else
			$display("circular_deque: mismatch");
		$finish;
	end

endmodule

// File: sim.f
sv/dq_pkg.sv
sv/dq_req_if.sv
sv/dq_rsp_if.sv
sv/dq_ram.sv
sv/circular_deque.sv
test/circular_deque_tb.sv
